// File: rtl/bitp_pkg.sv
// Shared types, character codes and the control store of the infix to postfix converter.
// Imported by boolean_infix_to_postfix_core; no dependencies of its own.
package bitp_pkg;

  // Operator stack entries
  typedef logic [1:0] op_t;
  localparam op_t OP_NOT  = 2'd0;
  localparam op_t OP_AND  = 2'd1;
  localparam op_t OP_OR   = 2'd2;
  localparam op_t OP_OPEN = 2'd3;

  // Result token kinds
  typedef logic [1:0] kind_t;
  localparam kind_t TK_VAR = 2'd0;
  localparam kind_t TK_OP  = 2'd1;
  localparam kind_t TK_END = 2'd2;

  // Error codes
  typedef logic [1:0] err_t;
  localparam err_t ERR_NONE     = 2'd0;
  localparam err_t ERR_OVERFLOW = 2'd1;
  localparam err_t ERR_CLOSE    = 2'd2;
  localparam err_t ERR_OPEN     = 2'd3;

  // Character codes
  localparam logic [7:0] CH_NOT   = 8'h21;
  localparam logic [7:0] CH_AND   = 8'h2A;
  localparam logic [7:0] CH_OR    = 8'h2B;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CASE_GAP = 8'd32;

  // Microprogram step addresses
  typedef logic [3:0] step_t;
  localparam step_t S_IDLE       = 4'd0;
  localparam step_t S_LETTER     = 4'd1;
  localparam step_t S_OPLOOP     = 4'd2;
  localparam step_t S_OPPOP      = 4'd3;
  localparam step_t S_OPFETCH    = 4'd4;
  localparam step_t S_PUSH       = 4'd5;
  localparam step_t S_CLOSE      = 4'd6;
  localparam step_t S_CLOSEPOP   = 4'd7;
  localparam step_t S_CLOSEFETCH = 4'd8;
  localparam step_t S_CLOSEERR   = 4'd9;
  localparam step_t S_ENDCHK     = 4'd10;
  localparam step_t S_FLUSH      = 4'd11;
  localparam step_t S_FLUSHPOP   = 4'd12;
  localparam step_t S_FLUSHFETCH = 4'd13;
  localparam step_t S_ENDTOK     = 4'd14;

  // Jump conditions
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_END,
    C_EMPTY,
    C_NO_POP,
    C_POPPED_OPEN,
    C_DISPATCH
  } cond_e;

  // Token emission selects
  typedef enum logic [2:0] {
    EM_NONE,
    EM_VAR,
    EM_TOP,
    EM_POPPED,
    EM_OP_POPPED,
    EM_END
  } emit_e;

  typedef struct packed {
    cond_e cond;
    step_t tgt_t;
    step_t tgt_f;
    emit_e emit;
    logic  pop;
    logic  push;
    logic  load;
    err_t  flag;
    logic  clear;
  } ctrl_t;

  function automatic logic [1:0] prec(op_t op);
    logic [1:0] p;
    unique case (op)
      OP_NOT:  p = 2'd3;
      OP_AND:  p = 2'd2;
      OP_OR:   p = 2'd1;
      default: p = 2'd0;
    endcase
    return p;
  endfunction

  // Control store: one word per step
  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    w = '{cond: C_ALWAYS, tgt_t: S_IDLE, tgt_f: S_IDLE, emit: EM_NONE, pop: 1'b0,
          push: 1'b0, load: 1'b0, flag: ERR_NONE, clear: 1'b0};
    unique case (s)
      S_IDLE: begin
        w.cond = C_DISPATCH;
      end
      S_LETTER: begin
        w.emit = EM_VAR;
        w.cond = C_END; w.tgt_t = S_FLUSH; w.tgt_f = S_IDLE;
      end
      S_OPLOOP: begin
        w.cond = C_NO_POP; w.tgt_t = S_PUSH; w.tgt_f = S_OPPOP;
      end
      S_OPPOP: begin
        w.pop = 1'b1; w.tgt_t = S_OPFETCH;
      end
      S_OPFETCH: begin
        w.load = 1'b1; w.emit = EM_OP_POPPED; w.tgt_t = S_OPLOOP;
      end
      S_PUSH: begin
        w.push = 1'b1;
        w.cond = C_END; w.tgt_t = S_FLUSH; w.tgt_f = S_IDLE;
      end
      S_CLOSE: begin
        w.cond = C_EMPTY; w.tgt_t = S_CLOSEERR; w.tgt_f = S_CLOSEPOP;
      end
      S_CLOSEPOP: begin
        w.pop = 1'b1; w.tgt_t = S_CLOSEFETCH;
      end
      S_CLOSEFETCH: begin
        w.load = 1'b1; w.emit = EM_POPPED;
        w.cond = C_POPPED_OPEN; w.tgt_t = S_ENDCHK; w.tgt_f = S_CLOSE;
      end
      S_CLOSEERR: begin
        w.flag = ERR_CLOSE;
        w.cond = C_END; w.tgt_t = S_FLUSH; w.tgt_f = S_IDLE;
      end
      S_ENDCHK: begin
        w.cond = C_END; w.tgt_t = S_FLUSH; w.tgt_f = S_IDLE;
      end
      S_FLUSH: begin
        w.cond = C_EMPTY; w.tgt_t = S_ENDTOK; w.tgt_f = S_FLUSHPOP;
      end
      S_FLUSHPOP: begin
        w.emit = EM_TOP; w.pop = 1'b1; w.flag = ERR_OPEN; w.tgt_t = S_FLUSHFETCH;
      end
      S_FLUSHFETCH: begin
        w.load = 1'b1; w.tgt_t = S_FLUSH;
      end
      S_ENDTOK: begin
        w.emit = EM_END; w.clear = 1'b1;
      end
      default: ;
    endcase
    return w;
  endfunction

endpackage

// File: rtl/bitp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependencies.
module bitp_ram #(
  parameter int unsigned Width = 2,
  parameter int unsigned Depth = 31,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/boolean_infix_to_postfix_core.sv
// Shunting-yard converter: a letter emits its variable token, '(' is pushed, an ignored character
// is dropped, an operator pops and emits each entry of equal or higher precedence before its push,
// ')' pops up to its '(' and flags an error when none is found, and an end mark flushes the rest
// and emits the end token. A stalled output holds the sequencer on its emitting step. First result
// appears in the cycle after the emitting step. Reset (rst_ni low, asynchronous) empties the stack,
// clears all counts and flags and drops the output valid.
module boolean_infix_to_postfix_core
  import bitp_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        expr_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  token_kind_o,
  output logic [4:0]  letter_o,
  output logic [4:0]  var_index_o,
  output logic [1:0]  op_code_o,
  output logic [9:0]  literal_total_o,
  output logic [4:0]  variable_total_o,
  output logic [1:0]  error_code_o,
  output logic        last_token_o
);

  localparam int unsigned LvlW     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned RamDepth = STACK_DEPTH - 1;
  localparam int unsigned RamAw    = (RamDepth > 1) ? $clog2(RamDepth) : 1;

  // Sequencer
  step_t pc_q, pc_d;
  ctrl_t cw;
  logic  go;
  logic  take;
  step_t dispatch_tgt;

  // Stack: top entry in a register, the rest in RAM
  logic [LvlW-1:0] level_q, level_d;
  op_t  top_q, top_d;
  op_t  popped_q, popped_d;
  logic stack_full;
  logic ram_we, ram_re;
  logic [RamAw-1:0] ram_waddr, ram_raddr;
  op_t  ram_rdata;

  // Current item
  op_t  cur_op_q, cur_op_d;
  logic [4:0] letter_q, letter_d;
  logic end_q, end_d;

  // Expression totals
  logic [25:0] seen_q, seen_d;
  logic [4:0]  num_q [26];
  logic        num_we;
  logic [4:0]  next_q, next_d;
  logic [9:0]  lit_q, lit_d;
  err_t        err_q, err_d;
  err_t        err_set;

  // Output register
  logic       out_valid_q, out_valid_d;
  kind_t      kind_q, kind_d;
  logic [4:0] out_letter_q, out_letter_d;
  logic [4:0] var_idx_q, var_idx_d;
  op_t        op_code_q, op_code_d;
  logic [9:0] lit_tot_q, lit_tot_d;
  logic [4:0] var_tot_q, var_tot_d;
  err_t       err_code_q, err_code_d;
  logic       last_q, last_d;
  logic       out_free;
  logic       emit_req;

  // Character decode
  logic [7:0] c_up;
  logic is_letter, is_op, is_open, is_close;
  op_t  in_op;

  assign c_up      = (char_code_i >= CH_LA && char_code_i <= CH_LZ) ?
                     char_code_i - CASE_GAP : char_code_i;
  assign is_letter = (c_up >= CH_UA) && (c_up <= CH_UZ);
  assign is_op     = (c_up == CH_NOT) || (c_up == CH_AND) || (c_up == CH_OR);
  assign is_open   = (c_up == CH_OPEN);
  assign is_close  = (c_up == CH_CLOSE);

  always_comb begin
    priority if (c_up == CH_NOT) begin
      in_op = OP_NOT;
    end else if (c_up == CH_AND) begin
      in_op = OP_AND;
    end else if (c_up == CH_OR) begin
      in_op = OP_OR;
    end else begin
      in_op = OP_OPEN;
    end
  end

  always_comb begin
    priority if (!in_valid_i) begin
      dispatch_tgt = S_IDLE;
    end else if (is_letter) begin
      dispatch_tgt = S_LETTER;
    end else if (is_op) begin
      dispatch_tgt = S_OPLOOP;
    end else if (is_open) begin
      dispatch_tgt = S_PUSH;
    end else if (is_close) begin
      dispatch_tgt = S_CLOSE;
    end else if (expr_end_i) begin
      dispatch_tgt = S_FLUSH;
    end else begin
      dispatch_tgt = S_IDLE;
    end
  end

  assign cw         = ucode(pc_q);
  assign in_ready_o = (pc_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;
  assign stack_full = (level_q == LvlW'(STACK_DEPTH));

  always_comb begin
    unique case (cw.emit)
      EM_VAR, EM_END, EM_OP_POPPED: emit_req = 1'b1;
      EM_TOP:         emit_req = (top_q != OP_OPEN);
      EM_POPPED:      emit_req = (popped_q != OP_OPEN);
      default:        emit_req = 1'b0;
    endcase
  end

  // Hold the step while its token cannot be placed
  assign go = !emit_req || out_free;

  always_comb begin
    unique case (cw.cond)
      C_END:         take = end_q;
      C_EMPTY:       take = (level_q == '0);
      C_NO_POP:      take = (level_q == '0) || (prec(top_q) < prec(cur_op_q));
      C_POPPED_OPEN: take = (popped_q == OP_OPEN);
      default:       take = 1'b1;
    endcase
  end

  always_comb begin
    pc_d = pc_q;
    if (go) begin
      if (cw.cond == C_DISPATCH) begin
        pc_d = dispatch_tgt;
      end else begin
        pc_d = take ? cw.tgt_t : cw.tgt_f;
      end
    end
  end

  // Datapath
  always_comb begin
    level_d   = level_q;
    top_d     = top_q;
    popped_d  = popped_q;
    cur_op_d  = cur_op_q;
    letter_d  = letter_q;
    end_d     = end_q;
    seen_d    = seen_q;
    next_d    = next_q;
    lit_d     = lit_q;
    err_d     = err_q;
    err_set   = ERR_NONE;
    num_we    = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = RamAw'(level_q - LvlW'(1));
    ram_raddr = RamAw'(level_q - LvlW'(2));

    if (in_valid_i && in_ready_o) begin
      cur_op_d = in_op;
      letter_d = 5'(c_up - CH_UA);
      end_d    = expr_end_i;
    end

    if (go) begin
      if (cw.emit == EM_VAR) begin
        if (lit_q != '1) begin
          lit_d = lit_q + 10'd1;
        end
        if (!seen_q[letter_q]) begin
          seen_d[letter_q] = 1'b1;
          num_we           = 1'b1;
          next_d           = next_q + 5'd1;
        end
      end

      if (cw.push) begin
        if (stack_full) begin
          err_set = ERR_OVERFLOW;
        end else begin
          ram_we  = (level_q != '0);
          top_d   = cur_op_q;
          level_d = level_q + LvlW'(1);
        end
      end

      if (cw.pop) begin
        popped_d = top_q;
        level_d  = level_q - LvlW'(1);
        ram_re   = (level_q > LvlW'(1));
      end

      if (cw.load) begin
        top_d = ram_rdata;
      end

      if (cw.flag == ERR_CLOSE) begin
        err_set = ERR_CLOSE;
      end else if (cw.flag == ERR_OPEN && top_q == OP_OPEN) begin
        err_set = ERR_OPEN;
      end

      // Keep only the first error of an expression
      if (err_set != ERR_NONE && err_q == ERR_NONE) begin
        err_d = err_set;
      end

      if (cw.clear) begin
        level_d = '0;
        seen_d  = '0;
        next_d  = '0;
        lit_d   = '0;
        err_d   = ERR_NONE;
      end
    end
  end

  // Token formation
  always_comb begin
    out_valid_d  = out_valid_q && !out_ready_i;
    kind_d       = kind_q;
    out_letter_d = out_letter_q;
    var_idx_d    = var_idx_q;
    op_code_d    = op_code_q;
    lit_tot_d    = lit_tot_q;
    var_tot_d    = var_tot_q;
    err_code_d   = err_code_q;
    last_d       = last_q;

    if (emit_req && out_free) begin
      out_valid_d  = 1'b1;
      kind_d       = TK_OP;
      out_letter_d = '0;
      var_idx_d    = '0;
      op_code_d    = OP_NOT;
      lit_tot_d    = '0;
      var_tot_d    = '0;
      err_code_d   = ERR_NONE;
      last_d       = 1'b0;
      unique case (cw.emit)
        EM_VAR: begin
          kind_d       = TK_VAR;
          out_letter_d = letter_q;
          var_idx_d    = seen_q[letter_q] ? num_q[letter_q] : next_q;
          last_d       = !end_q;
        end
        EM_TOP: begin
          op_code_d = top_q;
        end
        EM_OP_POPPED: begin
          op_code_d = popped_q;
          // Last when the next entry stays on the stack for this operator
          last_d    = !end_q && ((level_q == '0) || (prec(ram_rdata) < prec(cur_op_q)));
        end
        EM_POPPED: begin
          op_code_d = popped_q;
          // Last when the close finishes here: the next entry is '(' or none
          last_d    = !end_q && ((level_q == '0) || (ram_rdata == OP_OPEN));
        end
        EM_END: begin
          kind_d     = TK_END;
          lit_tot_d  = lit_q;
          var_tot_d  = next_q;
          err_code_d = err_q;
          last_d     = 1'b1;
        end
        default: ;
      endcase
    end
  end

  bitp_ram #(
    .Width(2),
    .Depth(RamDepth)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(top_q),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= S_IDLE;
      level_q     <= '0;
      seen_q      <= '0;
      next_q      <= '0;
      lit_q       <= '0;
      err_q       <= ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      level_q     <= level_d;
      seen_q      <= seen_d;
      next_q      <= next_d;
      lit_q       <= lit_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q        <= top_d;
    popped_q     <= popped_d;
    cur_op_q     <= cur_op_d;
    letter_q     <= letter_d;
    end_q        <= end_d;
    kind_q       <= kind_d;
    out_letter_q <= out_letter_d;
    var_idx_q    <= var_idx_d;
    op_code_q    <= op_code_d;
    lit_tot_q    <= lit_tot_d;
    var_tot_q    <= var_tot_d;
    err_code_q   <= err_code_d;
    last_q       <= last_d;
    if (num_we) begin
      num_q[letter_q] <= next_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign token_kind_o     = kind_q;
  assign letter_o         = out_letter_q;
  assign var_index_o      = var_idx_q;
  assign op_code_o        = op_code_q;
  assign literal_total_o  = lit_tot_q;
  assign variable_total_o = var_tot_q;
  assign error_code_o     = err_code_q;
  assign last_token_o     = last_q;

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LvlW'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && token_kind_o == TK_END) |-> last_token_o)
    else $error("end token not marked last");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == S_ENDTOK && go) |=> (level_q == '0 && next_q == '0 && pc_q == S_IDLE))
    else $error("state not cleared after end token");

  a_full_push_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cw.push && go && stack_full) |=> (level_q == LvlW'(STACK_DEPTH) && err_q != ERR_NONE))
    else $error("push on full stack not dropped");

  a_ready_idle_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> (cw.cond == C_DISPATCH))
    else $error("input taken outside the dispatch step");

endmodule
